// ----- src/sra_pkg.sv -----
package sra_pkg;

	localparam int MAX_BYTES    = 4096;
	localparam int MAX_SEGMENTS = 256;

	// fixed field widths
	localparam int TB_W  = 13;   // byte counts, total_bytes
	localparam int SC_W  = 9;    // segment counts
	localparam int ID_W  = 64;
	localparam int W32   = 32;
	localparam int CFG_W = 64;
	localparam int CIX_W = 3;

	// derived internal widths
	localparam int BA_W     = $clog2(MAX_BYTES);      // store address
	localparam int SI_W     = $clog2(MAX_SEGMENTS);   // segment index
	localparam int COV_W    = 32;                     // coverage bits per row
	localparam int CB_W     = $clog2(COV_W);
	localparam int COV_ROWS = MAX_BYTES / COV_W;
	localparam int CR_W     = $clog2(COV_ROWS);
	localparam int SEEN_W   = MAX_SEGMENTS / COV_ROWS; // seen bits per row
	localparam int SW_B     = $clog2(SEEN_W);

	typedef enum logic [1:0] {
		FN_HEADER  = 2'd0,
		FN_DATA    = 2'd1,
		FN_READ    = 2'd2,
		FN_RESTART = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		ST_OK         = 4'd0,
		ST_MAGIC      = 4'd1,
		ST_IDENT      = 4'd2,
		ST_INDEX      = 4'd3,
		ST_RANGE      = 4'd4,
		ST_DUP        = 4'd5,
		ST_OVERLAP    = 4'd6,
		ST_UNEXPECTED = 4'd7,
		ST_INCOMPLETE = 4'd8,
		ST_UNCONFIG   = 4'd9
	} status_t;

	typedef enum logic [CIX_W-1:0] {
		CFG_TOTAL_BYTES   = 3'd0,
		CFG_SEGMENT_TOTAL = 3'd1,
		CFG_STREAM_IDENT  = 3'd2,
		CFG_REQUEST_IDENT = 3'd3,
		CFG_MESSAGE_IDENT = 3'd4,
		CFG_MAGIC         = 3'd5,
		CFG_VERSION       = 3'd6
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_SEEN, S_SCAN, S_CHECK, S_MRD, S_MWR, S_COMMIT, S_RESP
	} bstate_t;

	typedef struct packed {
		logic [TB_W-1:0] total_bytes;
		logic [SC_W-1:0] segment_total;
		logic [ID_W-1:0] stream_ident;
		logic [ID_W-1:0] request_ident;
		logic [ID_W-1:0] message_ident;
		logic [W32-1:0]  expected_magic;
		logic [7:0]      expected_version;
	} cfg_t;

	// classified command handed from front to back
	typedef struct packed {
		func_t           func;
		logic            unconf;   // registers not usable
		status_t         pre;      // header checks that need no state
		logic            oor;      // read address beyond message
		logic [SI_W-1:0] idx;
		logic [TB_W-1:0] off;
		logic [TB_W-1:0] len;
		logic [7:0]      dbyte;
	} cmd_t;

	function automatic logic cfg_bad(input cfg_t c);
		return (c.segment_total == '0) || (32'(c.segment_total) > 32'(MAX_SEGMENTS)) ||
			(32'(c.total_bytes) > 32'(MAX_BYTES));
	endfunction

endpackage

// ----- src/sra_front.sv -----
module sra_front import sra_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	input  logic            push,
	output logic            full,
	input  logic [1:0]      func,
	input  logic [W32-1:0]  seg_magic,
	input  logic [7:0]      seg_version,
	input  logic [ID_W-1:0] seg_stream_id,
	input  logic [ID_W-1:0] seg_request_id,
	input  logic [ID_W-1:0] seg_message_id,
	input  logic [W32-1:0]  seg_count_claimed,
	input  logic [W32-1:0]  seg_total_claimed,
	input  logic [W32-1:0]  seg_index,
	input  logic [W32-1:0]  byte_offset,
	input  logic [W32-1:0]  payload_len,
	input  logic [7:0]      data_byte,
	output logic            hd_valid,
	output cmd_t            hd_cmd,
	input  logic            hd_take
);

	cmd_t          cmd;
	cmd_t          q_q [2];
	logic          wr_q, rd_q;
	logic [1:0]    cnt_q;
	logic [W32-1:0] tot32, seg32;
	logic          wr, rd;

	always_comb begin
		tot32 = W32'(cfg.total_bytes);
		seg32 = W32'(cfg.segment_total);
		cmd.func   = func_t'(func);
		cmd.unconf = cfg_bad(cfg);
		cmd.oor    = byte_offset >= tot32;
		cmd.idx    = seg_index[SI_W-1:0];
		cmd.off    = byte_offset[TB_W-1:0];
		cmd.len    = payload_len[TB_W-1:0];
		cmd.dbyte  = data_byte;
		priority if (seg_magic != cfg.expected_magic || seg_version != cfg.expected_version)
			cmd.pre = ST_MAGIC;
		else if (seg_stream_id != cfg.stream_ident || seg_request_id != cfg.request_ident ||
			seg_message_id != cfg.message_ident || seg_count_claimed != seg32 ||
			seg_total_claimed != tot32)
			cmd.pre = ST_IDENT;
		else if (seg_index >= seg32)
			cmd.pre = ST_INDEX;
		else if (byte_offset > tot32 || payload_len > tot32 - byte_offset)
			cmd.pre = ST_RANGE;
		else
			cmd.pre = ST_OK;
	end

	assign full     = cnt_q[1];
	assign hd_valid = cnt_q != '0;
	assign hd_cmd   = q_q[rd_q];
	assign wr       = push && !full;
	assign rd       = hd_take && hd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wr_q <= !wr_q;
			if (rd) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) q_q[wr_q] <= cmd;
	end

endmodule

// ----- src/sra_back.sv -----
module sra_back import sra_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	input  logic            hd_valid,
	input  cmd_t            hd_cmd,
	output logic            hd_take,
	input  logic            pop,
	output logic            out_valid,
	output status_t         out_status,
	output logic            out_complete,
	output logic [7:0]      out_rd,
	output logic [SC_W-1:0] out_seg,
	output logic [TB_W-1:0] out_bytes
);

	bstate_t           state_q, nxt;
	logic [SEEN_W-1:0] seen_mem [COV_ROWS];
	logic [SEEN_W-1:0] seen_rd_q, seen_wd;
	logic [CR_W-1:0]   seen_wa;
	logic              seen_we, seen_hit;
	logic [SC_W-1:0]   seg_cnt_q;
	logic [TB_W-1:0]   byte_cnt_q, wp_q, pend_q, end_q;
	logic [CR_W-1:0]   row_q, last_q;
	logic              clr_resp_q, rdsel_q;
	cmd_t              cur_q;
	status_t           status_q, idle_status;
	logic [COV_W-1:0]  cov_mem [COV_ROWS];
	logic [COV_W-1:0]  cov_rd_q, mask, cov_wd;
	logic [7:0]        store_mem [MAX_BYTES];
	logic [7:0]        store_rd_q;
	logic              complete_now, overlap, row_last, out_free, hdr_go;
	logic              cov_we, cov_re, store_we, store_re;
	logic [TB_W-1:0]   h_end, h_end_m1, pos;

	assign complete_now = !cfg_bad(cfg) && seg_cnt_q == cfg.segment_total &&
		byte_cnt_q == cfg.total_bytes && pend_q == '0;
	assign out_free = !out_valid || pop;
	assign row_last = row_q == last_q;
	assign h_end    = hd_cmd.off + hd_cmd.len;
	assign h_end_m1 = h_end - TB_W'(1);
	assign seen_hit = seen_rd_q[cur_q.idx[SW_B-1:0]];

	always_comb begin
		pos = '0;
		for (int j = 0; j < COV_W; j++) begin
			pos = {1'b0, row_q, CB_W'(j)};
			mask[j] = pos >= cur_q.off && pos < end_q;
		end
	end
	assign overlap = |(cov_rd_q & mask);

	// status of the head command judged against current state;
	// the duplicate check follows in the next cycle from the seen map
	always_comb begin
		idle_status = ST_OK;
		if (hd_cmd.func != FN_RESTART && hd_cmd.unconf) begin
			idle_status = ST_UNCONFIG;
		end else begin
			unique case (hd_cmd.func)
				FN_HEADER: begin
					priority if (pend_q != '0) idle_status = ST_UNEXPECTED;
					else if (hd_cmd.pre != ST_OK) idle_status = hd_cmd.pre;
					else idle_status = ST_OK;
				end
				FN_DATA: idle_status = (pend_q == '0) ? ST_UNEXPECTED : ST_OK;
				FN_READ: begin
					priority if (!complete_now) idle_status = ST_INCOMPLETE;
					else if (hd_cmd.oor) idle_status = ST_RANGE;
					else idle_status = ST_OK;
				end
				FN_RESTART: idle_status = ST_OK;
				default: idle_status = ST_OK;
			endcase
		end
	end
	assign hdr_go = hd_cmd.func == FN_HEADER && idle_status == ST_OK;

	// next state
	always_comb begin
		nxt = state_q;
		unique case (state_q)
			S_CLEAR: if (row_q == CR_W'(COV_ROWS - 1)) nxt = clr_resp_q ? S_RESP : S_IDLE;
			S_IDLE: begin
				if (hd_valid) begin
					priority if (hd_cmd.func == FN_RESTART) nxt = S_CLEAR;
					else if (hdr_go) nxt = S_SEEN;
					else nxt = S_RESP;
				end
			end
			S_SEEN: begin
				priority if (seen_hit) nxt = S_RESP;
				else if (cur_q.len == '0) nxt = S_COMMIT;
				else nxt = S_SCAN;
			end
			S_SCAN:   nxt = S_CHECK;
			S_CHECK: begin
				priority if (overlap) nxt = S_RESP;
				else if (row_last) nxt = S_MRD;
				else nxt = S_SCAN;
			end
			S_MRD:    nxt = S_MWR;
			S_MWR:    nxt = row_last ? S_COMMIT : S_MRD;
			S_COMMIT: nxt = S_RESP;
			S_RESP:   if (out_free) nxt = S_IDLE;
			default:  nxt = S_IDLE;
		endcase
	end

	// strobes
	always_comb begin
		hd_take  = state_q == S_IDLE && hd_valid;
		cov_re   = state_q == S_SCAN || state_q == S_MRD;
		cov_we   = state_q == S_CLEAR || state_q == S_MWR;
		cov_wd   = (state_q == S_MWR) ? (cov_rd_q | mask) : '0;
		seen_we  = state_q == S_CLEAR || state_q == S_COMMIT;
		seen_wa  = (state_q == S_CLEAR) ? row_q : cur_q.idx[SI_W-1:SW_B];
		seen_wd  = (state_q == S_CLEAR) ? '0 :
			(seen_rd_q | (SEEN_W'(1) << cur_q.idx[SW_B-1:0]));
		store_we = hd_take && hd_cmd.func == FN_DATA && idle_status == ST_OK &&
			!wp_q[TB_W-1];
		store_re = hd_take && hd_cmd.func == FN_READ && idle_status == ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			seg_cnt_q    <= '0;
			byte_cnt_q   <= '0;
			wp_q         <= '0;
			pend_q       <= '0;
			end_q        <= '0;
			row_q        <= '0;
			last_q       <= '0;
			clr_resp_q   <= 1'b0;
			rdsel_q      <= 1'b0;
			cur_q        <= '0;
			status_q     <= ST_OK;
			out_valid    <= 1'b0;
			out_status   <= ST_OK;
			out_complete <= 1'b0;
			out_rd       <= '0;
			out_seg      <= '0;
			out_bytes    <= '0;
		end else begin
			state_q <= nxt;
			if (state_q == S_RESP && out_free) out_valid <= 1'b1;
			else if (pop) out_valid <= 1'b0;
			unique case (state_q)
				S_CLEAR: row_q <= row_q + CR_W'(1);
				S_IDLE: begin
					if (hd_take) begin
						cur_q    <= hd_cmd;
						status_q <= idle_status;
						rdsel_q  <= store_re;
						end_q    <= h_end;
						last_q   <= h_end_m1[BA_W-1:CB_W];
						if (hd_cmd.func == FN_RESTART) begin
							seg_cnt_q  <= '0;
							byte_cnt_q <= '0;
							wp_q       <= '0;
							pend_q     <= '0;
							row_q      <= '0;
							clr_resp_q <= 1'b1;
						end else begin
							row_q <= hd_cmd.off[BA_W-1:CB_W];
							if (hd_cmd.func == FN_DATA && idle_status == ST_OK) begin
								wp_q   <= wp_q + TB_W'(1);
								pend_q <= pend_q - TB_W'(1);
							end
						end
					end
				end
				S_SEEN: if (seen_hit) status_q <= ST_DUP;
				S_SCAN: ;
				S_CHECK: begin
					if (overlap) status_q <= ST_OVERLAP;
					else row_q <= row_last ? cur_q.off[BA_W-1:CB_W] : row_q + CR_W'(1);
				end
				S_MRD: ;
				S_MWR: row_q <= row_q + CR_W'(1);
				S_COMMIT: begin
					seg_cnt_q  <= seg_cnt_q + SC_W'(1);
					byte_cnt_q <= byte_cnt_q + cur_q.len;
					wp_q       <= cur_q.off;
					pend_q     <= cur_q.len;
				end
				S_RESP: begin
					if (out_free) begin
						out_status   <= status_q;
						out_complete <= complete_now;
						out_rd       <= rdsel_q ? store_rd_q : '0;
						out_seg      <= seg_cnt_q;
						out_bytes    <= byte_cnt_q;
						clr_resp_q   <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cov_we) cov_mem[row_q] <= cov_wd;
		if (cov_re) cov_rd_q <= cov_mem[row_q];
	end

	// seen map: two index bits per row, cleared with the coverage map
	always_ff @(posedge clk) begin
		if (seen_we) seen_mem[seen_wa] <= seen_wd;
		if (hd_take) seen_rd_q <= seen_mem[hd_cmd.idx[SI_W-1:SW_B]];
	end

	always_ff @(posedge clk) begin
		if (store_we) store_mem[wp_q[BA_W-1:0]] <= hd_cmd.dbyte;
		if (store_re) store_rd_q <= store_mem[hd_cmd.off[BA_W-1:0]];
	end

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		hd_take |-> state_q == S_IDLE)
		else $error("command taken outside idle");
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != '0 |-> (32'(wp_q) + 32'(pend_q)) <= 32'(MAX_BYTES))
		else $error("pending bytes run past store");
	a_resp_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && out_free) |=> out_valid && state_q == S_IDLE)
		else $error("result not posted");
	a_commit_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_COMMIT |=> pend_q == $past(cur_q.len))
		else $error("pending count not armed");

endmodule

// ----- src/segment_reassembly_engine_unit.sv -----
// channel | beat accepted when     | payload
// input   | push && !full          | func, seg_* fields, byte_offset, payload_len, data_byte
// result  | pop && !empty          | status, complete, read_data, segments_received,
//         |                        | bytes_received
// config  | cfg_we                 | cfg_index, cfg_data
//
// Data, read and rejected items go from idle straight to the result state in the back end;
// a duplicate header goes through the seen lookup first. An accepted header passes seen
// lookup, a check walk over its coverage rows (32 bytes a row) in scan and check states,
// a mark walk in read and write states, commit and result. A zero-length header skips
// both walks. Restart and reset clear the coverage and seen maps, all 128 rows, one row
// a cycle, during which no beat leaves the input queue (the 2-deep queue still fills).
// A waiting result holds the back end in its result state until pop; the front queue
// still takes two beats before full rises.
module segment_reassembly_engine_unit import sra_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CIX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             push,
	output logic             full,
	input  logic [1:0]       func,
	input  logic [W32-1:0]   seg_magic,
	input  logic [7:0]       seg_version,
	input  logic [ID_W-1:0]  seg_stream_id,
	input  logic [ID_W-1:0]  seg_request_id,
	input  logic [ID_W-1:0]  seg_message_id,
	input  logic [W32-1:0]   seg_count_claimed,
	input  logic [W32-1:0]   seg_total_claimed,
	input  logic [W32-1:0]   seg_index,
	input  logic [W32-1:0]   byte_offset,
	input  logic [W32-1:0]   payload_len,
	input  logic [7:0]       data_byte,
	output logic             empty,
	input  logic             pop,
	output logic [3:0]       status,
	output logic             complete,
	output logic [7:0]       read_data,
	output logic [SC_W-1:0]  segments_received,
	output logic [TB_W-1:0]  bytes_received
);

	cfg_t    cfg_q;
	logic    hd_valid, hd_take, out_valid;
	cmd_t    hd_cmd;
	status_t out_status;

	// configuration registers; index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TOTAL_BYTES:   cfg_q.total_bytes      <= cfg_data[TB_W-1:0];
				CFG_SEGMENT_TOTAL: cfg_q.segment_total    <= cfg_data[SC_W-1:0];
				CFG_STREAM_IDENT:  cfg_q.stream_ident     <= cfg_data;
				CFG_REQUEST_IDENT: cfg_q.request_ident    <= cfg_data;
				CFG_MESSAGE_IDENT: cfg_q.message_ident    <= cfg_data;
				CFG_MAGIC:         cfg_q.expected_magic   <= cfg_data[W32-1:0];
				CFG_VERSION:       cfg_q.expected_version <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// front: classify against registers, queue two beats
	sra_front u_front (
		.clk, .arst_n, .cfg(cfg_q), .push, .full, .func, .seg_magic, .seg_version,
		.seg_stream_id, .seg_request_id, .seg_message_id, .seg_count_claimed,
		.seg_total_claimed, .seg_index, .byte_offset, .payload_len, .data_byte,
		.hd_valid, .hd_cmd, .hd_take
	);

	// back: state, coverage walk, payload store, result register
	sra_back u_back (
		.clk, .arst_n, .cfg(cfg_q), .hd_valid, .hd_cmd, .hd_take, .pop,
		.out_valid, .out_status, .out_complete(complete), .out_rd(read_data),
		.out_seg(segments_received), .out_bytes(bytes_received)
	);

	assign empty  = !out_valid;
	assign status = out_status;

endmodule
